// ----- hw/rtl/sdtq_pkg.sv -----
// Shared constants for the sorted deadline timer queue.
// Holds sizes, field widths, request kinds and result event codes.
// No dependencies.
`timescale 1ns / 1ps

package sdtq_pkg;

   // Queue size and derived widths.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths.
   localparam int KIND_W = 2;
   localparam int ID_W   = 8;
   localparam int INTV_W = 32;
   localparam int TIME_W = 48;
   localparam int EV_W   = 3;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // Result event codes.
   localparam logic [EV_W-1:0] EV_EXPIRED    = 3'd0;
   localparam logic [EV_W-1:0] EV_ADDED      = 3'd1;
   localparam logic [EV_W-1:0] EV_FULL       = 3'd2;
   localparam logic [EV_W-1:0] EV_ACTIVE     = 3'd3;
   localparam logic [EV_W-1:0] EV_REMOVED    = 3'd4;
   localparam logic [EV_W-1:0] EV_NOT_ACTIVE = 3'd5;
   localparam logic [EV_W-1:0] EV_NO_EXPIRY  = 3'd6;

endpackage

// ----- hw/rtl/sorted_deadline_timer_queue.sv -----
// One request is in work at a time: req_stall is high whenever the sequencer is not idle,
// and a new request beat is taken only in the idle state. A result stall holds a tick or a
// result beat until the receiver frees the output register.
// Reset clears the entry count, current time, active marks and handshakes.
// Deadline and id stores are not reset and are only read below the entry count.
`timescale 1ns / 1ps

module sorted_deadline_timer_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sdtq_pkg::KIND_W-1:0]   req_kind,
   input  logic [sdtq_pkg::ID_W-1:0]     req_timer_id,
   input  logic [sdtq_pkg::INTV_W-1:0]   req_interval_ms,
   input  logic [sdtq_pkg::TIME_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sdtq_pkg::EV_W-1:0]     rsp_event_res,
   output logic [sdtq_pkg::ID_W-1:0]     rsp_out_timer_id,
   output logic [sdtq_pkg::TIME_W-1:0]   rsp_deadline_ms,
   output logic                          rsp_last
);
   import sdtq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_TICK_SHIFT,
      ST_ADD_CHK,
      ST_ADD_INS,
      ST_RM,
      ST_EMIT
   } state_type;

   localparam int IDS = 2 ** ID_W;

   // Sorted timer stores.
   logic [TIME_W-1:0] dl_mem_ff [DEPTH];
   logic [ID_W-1:0]   id_mem_ff [DEPTH];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] cur_ff, cur_in;
   logic [IDS-1:0]    active_ff, active_in;
   logic              mark_ff, mark_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  hit_ff, hit_in;
   logic              found_ff, found_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [INTV_W-1:0] intv_ff, intv_in;
   logic [TIME_W-1:0] dl_ff, dl_in;
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [TIME_W-1:0] pend_dl_ff, pend_dl_in;
   logic [EV_W-1:0]   res_ev_ff, res_ev_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [EV_W-1:0]   rsp_ev_ff, rsp_ev_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic [CNT_W-1:0]  rd_sel;
   logic [TIME_W-1:0] rd_dl;
   logic [ID_W-1:0]   rd_id;
   logic [TIME_W-1:0] cmp_ref;
   logic              cmp_le;
   logic [TIME_W:0]   add_sum;
   logic [CNT_W-1:0]  src_sel;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [TIME_W-1:0] wr_dl;
   logic [ID_W-1:0]   wr_id;
   logic              due;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign src_sel  = idx_ff + hit_ff;

   // Read port select and the shared deadline comparator.
   always_comb begin
      unique case (state_ff)
         ST_ADD_INS:    rd_sel = idx_ff - CNT_W'(1);
         ST_TICK_SHIFT: rd_sel = src_sel;
         default:       rd_sel = idx_ff;
      endcase
      rd_dl   = dl_mem_ff[rd_sel[IDX_W-1:0]];
      rd_id   = id_mem_ff[rd_sel[IDX_W-1:0]];
      cmp_ref = (state_ff == ST_TICK) ? cur_ff : dl_ff;
      cmp_le  = rd_dl <= cmp_ref;
      add_sum = {1'b0, cur_ff} + {{(TIME_W + 1 - INTV_W){1'b0}}, intv_ff};
      due     = (idx_ff < count_ff) && cmp_le;
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      mark_in      = mark_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      id_in        = id_ff;
      intv_in      = intv_ff;
      dl_in        = dl_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      pend_dl_in   = pend_dl_ff;
      res_ev_in    = res_ev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ev_in    = rsp_ev_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_idx       = idx_ff[IDX_W-1:0];
      wr_dl        = rd_dl;
      wr_id        = rd_id;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in    = req_timer_id;
               intv_in  = req_interval_ms;
               mark_in  = active_ff[req_timer_id];
               idx_in   = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               unique case (req_kind)
                  KIND_TICK: begin
                     cur_in   = req_now_ms;
                     state_in = ST_TICK;
                  end
                  KIND_ADD:    state_in = ST_ADD_CHK;
                  KIND_REMOVE: state_in = ST_RM;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end

         // Walk the head of the queue; a held expiry is sent once the next entry is known.
         ST_TICK: begin
            if (pend_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_ev_in    = EV_EXPIRED;
                  rsp_id_in    = pend_id_ff;
                  rsp_dl_in    = pend_dl_ff;
                  rsp_last_in  = !due;
                  pend_in      = 1'b0;
               end
            end else if (due) begin
               pend_in            = 1'b1;
               pend_id_in         = rd_id;
               pend_dl_in         = rd_dl;
               active_in[rd_id]   = 1'b0;
               idx_in             = idx_ff + CNT_W'(1);
            end else if (idx_ff == '0) begin
               res_ev_in = EV_NO_EXPIRY;
               id_in     = '0;
               dl_in     = '0;
               state_in  = ST_EMIT;
            end else begin
               hit_in   = idx_ff;
               idx_in   = '0;
               state_in = ST_TICK_SHIFT;
            end
         end

         // Move surviving entries down over the expired ones.
         ST_TICK_SHIFT: begin
            if (src_sel >= count_ff) begin
               count_in = count_ff - hit_ff;
               state_in = ST_IDLE;
            end else begin
               wr_en  = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // Guards and saturating deadline.
         ST_ADD_CHK: begin
            dl_in = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];
            if (count_ff >= CNT_W'(DEPTH)) begin
               res_ev_in = EV_FULL;
               dl_in     = '0;
               state_in  = ST_EMIT;
            end else if (mark_ff) begin
               res_ev_in = EV_ACTIVE;
               dl_in     = '0;
               state_in  = ST_EMIT;
            end else begin
               idx_in   = count_ff;
               state_in = ST_ADD_INS;
            end
         end

         // Shift later deadlines up one slot until the insertion point is found.
         ST_ADD_INS: begin
            wr_en = 1'b1;
            if (idx_ff != '0 && !cmp_le) begin
               idx_in = idx_ff - CNT_W'(1);
            end else begin
               wr_dl            = dl_ff;
               wr_id            = id_ff;
               count_in         = count_ff + CNT_W'(1);
               active_in[id_ff] = 1'b1;
               res_ev_in        = EV_ADDED;
               state_in         = ST_EMIT;
            end
         end

         // Find the entry and close the gap behind it.
         ST_RM: begin
            if (!mark_ff) begin
               res_ev_in = EV_NOT_ACTIVE;
               dl_in     = '0;
               state_in  = ST_EMIT;
            end else if (idx_ff == count_ff) begin
               count_in         = count_ff - CNT_W'(1);
               active_in[id_ff] = 1'b0;
               res_ev_in        = EV_REMOVED;
               dl_in            = '0;
               state_in         = ST_EMIT;
            end else begin
               if (found_ff) begin
                  wr_en  = 1'b1;
                  wr_idx = IDX_W'(idx_ff - CNT_W'(1));
               end else if (rd_id == id_ff) begin
                  found_in = 1'b1;
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // Single-beat result for the request.
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = res_ev_ff;
               rsp_id_in    = id_ff;
               rsp_dl_in    = dl_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, stores and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         active_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mark_ff    <= mark_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      id_ff      <= id_in;
      intv_ff    <= intv_in;
      dl_ff      <= dl_in;
      pend_id_ff <= pend_id_in;
      pend_dl_ff <= pend_dl_in;
      res_ev_ff  <= res_ev_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_dl_ff  <= rsp_dl_in;
      rsp_last_ff <= rsp_last_in;
      if (wr_en) begin
         dl_mem_ff[wr_idx] <= wr_dl;
         id_mem_ff[wr_idx] <= wr_id;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ev_ff;
   assign rsp_out_timer_id = rsp_id_ff;
   assign rsp_deadline_ms  = rsp_dl_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   // The entry count never exceeds the queue size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above queue size");

   // Between requests, the number of active marks equals the entry count.
   a_marks_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(active_ff) == int'(count_ff)))
      else $error("active marks disagree with entry count");

   // A held expiry is always due at the current time.
   a_pend_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && pend_ff) |-> (pend_dl_ff <= cur_ff))
      else $error("held expiry is not due");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sorted deadline timer queue.
// Tick, add and remove beats are checked against a cycle-free shadow queue.
// Depends on sdtq_pkg and sorted_deadline_timer_queue.
`timescale 1ns / 1ps

module testbench;
   import sdtq_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_HOLD   = 500;
   localparam int TAIL_CYCLES = 64;
   localparam int MAX_REPORTS = 10;
   // The package has no name for the spare kind code; the block ignores it.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   timer_id;
      logic [INTV_W-1:0] interval_ms;
      logic [TIME_W-1:0] now_ms;
   } timer_req_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] deadline_ms;
      logic              last;
   } timer_note_type;

   // Clock, reset and block ports; the driven inputs are known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [ID_W-1:0] req_timer_id = '0;
   logic [INTV_W-1:0] req_interval_ms = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [EV_W-1:0] rsp_event_res;
   logic [ID_W-1:0] rsp_out_timer_id;
   logic [TIME_W-1:0] rsp_deadline_ms;
   logic rsp_last;

   always #5 clock = ~clock;

   sorted_deadline_timer_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_timer_id     (req_timer_id),
      .req_interval_ms  (req_interval_ms),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_out_timer_id (rsp_out_timer_id),
      .rsp_deadline_ms  (rsp_deadline_ms),
      .rsp_last         (rsp_last)
   );

   // Requests waiting to be sent and timer events still owed by the block.
   timer_req_type  pending_requests [$];
   timer_note_type awaited_events [$];

   // Shadow copy of the timer queue.
   logic [TIME_W-1:0] shadow_deadline [DEPTH];
   logic [ID_W-1:0]   shadow_id [DEPTH];
   int                shadow_count = 0;
   logic [TIME_W-1:0] shadow_now = '0;
   bit                shadow_active [256];

   // Run control, written by the stimulus process at the falling edge.
   bit quiet = 1'b0;
   bit want_long_hold = 1'b0;

   // Bookkeeping.
   int fail_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int event_seen [8];
   int expiry_run = 0;
   int longest_expiry_run = 0;
   int cycle_count = 0;
   int request_total = 0;
   logic [TIME_W-1:0] stim_time = '0;

   task automatic await_note(input logic [EV_W-1:0] ev, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] dl, input logic fin);
      timer_note_type note;
      note.event_res = ev;
      note.timer_id = id;
      note.deadline_ms = dl;
      note.last = fin;
      awaited_events.push_back(note);
   endtask

   // Apply one request to the shadow queue and queue the events it owes.
   task automatic predict_timer_events(input timer_req_type rq);
      int hits;
      int k;
      int j;
      int pos;
      logic [TIME_W:0] wide_sum;
      logic [TIME_W-1:0] dl;
      case (rq.kind)
         KIND_TICK: begin
            shadow_now = rq.now_ms;
            hits = 0;
            while (hits < shadow_count && shadow_deadline[hits] <= shadow_now)
               hits++;
            if (hits == 0)
               await_note(EV_NO_EXPIRY, '0, '0, 1'b1);
            for (k = 0; k < hits; k++) begin
               shadow_active[shadow_id[k]] = 1'b0;
               await_note(EV_EXPIRED, shadow_id[k], shadow_deadline[k], k == hits - 1);
            end
            for (k = hits; k < shadow_count; k++) begin
               shadow_deadline[k - hits] = shadow_deadline[k];
               shadow_id[k - hits] = shadow_id[k];
            end
            shadow_count -= hits;
         end
         KIND_ADD: begin
            // Every 8-bit id is below the id count, so no id is out of range; a full queue or an active id rejects.
            if (shadow_count >= DEPTH) begin
               await_note(EV_FULL, rq.timer_id, '0, 1'b1);
            end else if (shadow_active[rq.timer_id]) begin
               await_note(EV_ACTIVE, rq.timer_id, '0, 1'b1);
            end else begin
               wide_sum = {1'b0, shadow_now} + {{(TIME_W + 1 - INTV_W){1'b0}}, rq.interval_ms};
               dl = wide_sum[TIME_W] ? TIME_MAX : wide_sum[TIME_W-1:0];
               // Equal deadlines go behind the ones already queued.
               pos = 0;
               while (pos < shadow_count && shadow_deadline[pos] <= dl)
                  pos++;
               for (k = shadow_count; k > pos; k--) begin
                  shadow_deadline[k] = shadow_deadline[k - 1];
                  shadow_id[k] = shadow_id[k - 1];
               end
               shadow_deadline[pos] = dl;
               shadow_id[pos] = rq.timer_id;
               shadow_count++;
               shadow_active[rq.timer_id] = 1'b1;
               await_note(EV_ADDED, rq.timer_id, dl, 1'b1);
            end
         end
         KIND_REMOVE: begin
            if (!shadow_active[rq.timer_id]) begin
               await_note(EV_NOT_ACTIVE, rq.timer_id, '0, 1'b1);
            end else begin
               j = 0;
               for (k = 0; k < shadow_count; k++) begin
                  if (shadow_id[k] != rq.timer_id) begin
                     shadow_deadline[j] = shadow_deadline[k];
                     shadow_id[j] = shadow_id[k];
                     j++;
                  end
               end
               shadow_count = j;
               shadow_active[rq.timer_id] = 1'b0;
               await_note(EV_REMOVED, rq.timer_id, '0, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   // Request driver: holds a stalled beat, otherwise idles in bursts or sends the next one.
   int send_gap = 0;
   bit send_calm = 1'b0;
   timer_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid)
            accepted_count++;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet && !send_calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 18) - 1;
            req_valid <= 1'b0;
         end else begin
            next_req = pending_requests.pop_front();
            // The block takes requests in order, so the prediction can run now.
            predict_timer_events(next_req);
            req_valid <= 1'b1;
            req_kind <= next_req.kind;
            req_timer_id <= next_req.timer_id;
            req_interval_ms <= next_req.interval_ms;
            req_now_ms <= next_req.now_ms;
            if ($urandom_range(0, 49) == 0)
               send_calm = !send_calm;
         end
      end
   end

   // Result stall: random bursts, calm stretches, and one long hold-off on request.
   int stall_left = 0;
   bit recv_calm = 1'b0;
   bit long_hold_done = 1'b0;
   logic next_stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (want_long_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (!quiet && !recv_calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         if ($urandom_range(0, 199) == 0)
            recv_calm = !recv_calm;
         rsp_stall <= next_stall;
      end
   end

   // Result monitor: every accepted beat must match the oldest owed event.
   timer_note_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_events.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("Unexpected result: event %0d id %0d deadline %0h last %0b",
                        rsp_event_res, rsp_out_timer_id, rsp_deadline_ms, rsp_last);
         end else begin
            owed = awaited_events.pop_front();
            result_count++;
            event_seen[owed.event_res]++;
            if (rsp_event_res !== owed.event_res || rsp_out_timer_id !== owed.timer_id ||
                rsp_deadline_ms !== owed.deadline_ms || rsp_last !== owed.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $write("Mismatch at result %0d: want ev %0d id %0d dl %0h last %0b, ",
                         result_count, owed.event_res, owed.timer_id, owed.deadline_ms,
                         owed.last);
                  $display("got ev %0d id %0d dl %0h last %0b", rsp_event_res,
                           rsp_out_timer_id, rsp_deadline_ms, rsp_last);
               end
            end
         end
         // Track the longest run of expirations from one tick.
         if (rsp_event_res == EV_EXPIRED) begin
            expiry_run++;
            if (expiry_run > longest_expiry_run)
               longest_expiry_run = expiry_run;
         end
         if (rsp_last)
            expiry_run = 0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results owed", cycle_count,
                  awaited_events.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus helpers; fields a kind does not use carry random values.
   function automatic logic [TIME_W-1:0] random_time();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[TIME_W-1:0];
   endfunction

   task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                input logic [INTV_W-1:0] interval,
                                input logic [TIME_W-1:0] now);
      timer_req_type rq;
      rq.kind = kind;
      rq.timer_id = id;
      rq.interval_ms = interval;
      rq.now_ms = now;
      pending_requests.push_back(rq);
      if (kind != KIND_UNUSED)
         request_total++;
   endtask

   task automatic queue_tick(input logic [TIME_W-1:0] now);
      stim_time = now;
      queue_request(KIND_TICK, ID_W'($urandom_range(0, 255)), $urandom(), now);
   endtask

   task automatic queue_add(input logic [ID_W-1:0] id, input logic [INTV_W-1:0] interval);
      queue_request(KIND_ADD, id, interval, random_time());
   endtask

   task automatic queue_remove(input logic [ID_W-1:0] id);
      queue_request(KIND_REMOVE, id, $urandom(), random_time());
   endtask

   // Mostly a small id pool so removes and duplicate adds hit live timers.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 3) == 0)
         return ID_W'($urandom_range(0, 255));
      return ID_W'($urandom_range(0, 23));
   endfunction

   function automatic logic [INTV_W-1:0] pick_interval();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(0, 400);
      if (roll < 95)
         return $urandom_range(0, 5000);
      return $urandom();
   endfunction

   // Random traffic: mostly plausible timer use, with fill-and-flush bursts and noise.
   task automatic queue_random_traffic(input int count);
      int made;
      int pick;
      int base;
      int k;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            // Fill the queue past its depth, retry a live id, then tick far enough ahead to expire the burst.
            base = $urandom_range(0, 238);
            for (k = 0; k < 18; k++)
               queue_add(ID_W'(base + k), $urandom_range(0, 400));
            queue_add(ID_W'(base), $urandom_range(0, 400));
            if ($urandom_range(0, 1) == 0)
               queue_tick(TIME_MAX);
            else
               queue_tick(stim_time + 500);
            made += 20;
         end else if (pick < 40) begin
            queue_add(pick_id(), pick_interval());
            made++;
         end else if (pick < 58) begin
            queue_remove(pick_id());
            made++;
         end else if (pick < 84) begin
            queue_tick(stim_time + $urandom_range(0, 150));
            made++;
         end else if (pick < 88) begin
            queue_tick(stim_time - $urandom_range(1, 100));
            made++;
         end else if (pick < 92) begin
            queue_request(KIND_ADD, ID_W'($urandom_range(0, 255)), $urandom(), random_time());
            made++;
         end else if (pick < 96) begin
            queue_tick(random_time());
            made++;
         end else begin
            queue_request(KIND_UNUSED, ID_W'($urandom_range(0, 255)), $urandom(),
                          random_time());
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || awaited_events.size() != 0)
         @(negedge clock);
   endtask

   // Test sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corner cases.
      queue_tick('0);                       // nothing due on an empty queue
      queue_remove(8'd5);                   // remove of an idle id
      queue_add(8'd0, '0);                  // zero interval
      queue_add(8'd255, '1);                // largest id and interval
      queue_add(8'd0, 32'd7);               // id already active
      queue_tick('0);                       // deadline equal to the new time
      queue_add(8'd10, 32'd100);
      queue_add(8'd11, 32'd100);            // tie keeps add order
      queue_add(8'd12, 32'd50);             // sorts in front
      queue_remove(8'd11);
      queue_remove(8'd11);
      queue_tick(48'd100);                  // two expire in deadline order
      queue_request(KIND_UNUSED, '1, '1, '1);
      queue_tick(TIME_MAX);
      queue_add(8'd1, '1);                  // deadline saturates at the top
      queue_add(8'd2, '0);                  // equal to the saturated one
      queue_tick('0);                       // back to an earlier time
      queue_add(8'd3, 32'd20);
      queue_tick(TIME_MAX);                 // three expire
      queue_tick('0);
      wait_drained();

      // Random traffic, opened by a long hold-off on the result side.
      want_long_hold = 1'b1;
      queue_random_traffic(200);
      wait_drained();
      queue_random_traffic(200);
      wait_drained();

      // Closing stretch at full rate.
      quiet = 1'b1;
      queue_random_traffic(80);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests, %0d results: %0d expired, %0d added, %0d full, %0d dup",
               accepted_count, result_count, event_seen[EV_EXPIRED], event_seen[EV_ADDED],
               event_seen[EV_FULL], event_seen[EV_ACTIVE]);
      $display("%0d removed, %0d not active, %0d empty ticks, longest flush %0d, %0d failures",
               event_seen[EV_REMOVED], event_seen[EV_NOT_ACTIVE], event_seen[EV_NO_EXPIRY],
               longest_expiry_run, fail_count);
      if (fail_count == 0 && awaited_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sorted_deadline_timer_queue.f -----
hw/rtl/sdtq_pkg.sv
hw/rtl/sorted_deadline_timer_queue.sv
tb/testbench.sv
